// ----- rtl/spq_pkg.sv -----
// Shared types and codes for the stable minimum priority queue.
package spq_pkg;

  localparam logic MODE_ENQ = 1'b0;
  localparam logic MODE_DEQ = 1'b1;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic enq;
    logic deq;
  } cell_ctrl_t;

endpackage

// ----- rtl/spq_cell.sv -----
// One storage cell of the sorted chain: compares against a new entry and shifts.
module spq_cell #(
  parameter int PAYLOAD_WIDTH  = 32,
  parameter int PRIORITY_WIDTH = 16
) (
  input  logic                             clk,
  input  spq_pkg::cell_ctrl_t              ctrl,
  input  logic                             occupied,
  input  logic        [PAYLOAD_WIDTH-1:0]  new_pay,
  input  logic signed [PRIORITY_WIDTH-1:0] new_pri,
  input  logic                             prev_ge,
  input  logic        [PAYLOAD_WIDTH-1:0]  prev_pay,
  input  logic signed [PRIORITY_WIDTH-1:0] prev_pri,
  input  logic        [PAYLOAD_WIDTH-1:0]  next_pay,
  input  logic signed [PRIORITY_WIDTH-1:0] next_pri,
  output logic                             ge,
  output logic        [PAYLOAD_WIDTH-1:0]  pay,
  output logic signed [PRIORITY_WIDTH-1:0] pri
);

  // The cell lies at or after the insertion point when it is free or holds a later priority.
  assign ge = !occupied || (pri > new_pri);

  always_ff @(posedge clk) begin
    if (ctrl.enq && ge) begin
      if (prev_ge) begin
        pay <= prev_pay;
        pri <= prev_pri;
      end else begin
        pay <= new_pay;
        pri <= new_pri;
      end
    end else if (ctrl.deq) begin
      pay <= next_pay;
      pri <= next_pri;
    end
  end

endmodule

// ----- rtl/stable_min_priority_queue.sv -----
// Top level of the stable minimum priority queue built as a chain of sorted cells.
//
// Each transaction (enqueue or dequeue) is accepted when start is high and busy is low, and a new one
// may be started in every cycle; busy is high only during reset. Every cell compares its
// stored priority with the incoming one in parallel and shifts towards or away from the
// head, so the rate is one transaction per cycle at any depth. The result appears on the
// cycle after acceptance, marked by done for exactly one cycle, and cannot be held off.
module stable_min_priority_queue #(
  parameter int DEPTH          = 16,
  parameter int PAYLOAD_WIDTH  = 32,
  parameter int PRIORITY_WIDTH = 16,
  localparam int CountWidth    = $clog2(DEPTH + 1)
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic                             mode,
  input  logic        [PAYLOAD_WIDTH-1:0]  payload_in,
  input  logic signed [PRIORITY_WIDTH-1:0] priority_in,
  output logic                             done,
  output logic        [PAYLOAD_WIDTH-1:0]  payload_out,
  output logic signed [PRIORITY_WIDTH-1:0] priority_out,
  output logic        [1:0]                status,
  output logic        [CountWidth-1:0]     occupancy
);

  logic [CountWidth-1:0] count;
  logic [CountWidth-1:0] count_next;
  logic                  accept;
  logic                  full;
  logic                  empty;
  spq_pkg::cell_ctrl_t   ctrl;
  spq_pkg::status_t      status_next;

  logic                             cell_ge  [DEPTH];
  logic        [PAYLOAD_WIDTH-1:0]  cell_pay [DEPTH];
  logic signed [PRIORITY_WIDTH-1:0] cell_pri [DEPTH];

  assign busy   = rst;
  assign accept = start && !busy;
  assign full   = (count == CountWidth'(DEPTH));
  assign empty  = (count == '0);

  always_comb begin
    ctrl        = '0;
    status_next = spq_pkg::STATUS_OK;
    count_next  = count;
    if (accept) begin
      if (mode == spq_pkg::MODE_ENQ) begin
        if (full) begin
          status_next = spq_pkg::STATUS_FULL;
        end else begin
          ctrl.enq   = 1'b1;
          count_next = count + CountWidth'(1);
        end
      end else begin
        if (empty) begin
          status_next = spq_pkg::STATUS_EMPTY;
        end else begin
          ctrl.deq   = 1'b1;
          count_next = count - CountWidth'(1);
        end
      end
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                             prev_ge;
    logic        [PAYLOAD_WIDTH-1:0]  prev_pay;
    logic signed [PRIORITY_WIDTH-1:0] prev_pri;
    logic        [PAYLOAD_WIDTH-1:0]  next_pay;
    logic signed [PRIORITY_WIDTH-1:0] next_pri;

    if (i == 0) begin : g_head
      assign prev_ge  = 1'b0;
      assign prev_pay = payload_in;
      assign prev_pri = priority_in;
    end else begin : g_body
      assign prev_ge  = cell_ge[i-1];
      assign prev_pay = cell_pay[i-1];
      assign prev_pri = cell_pri[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign next_pay = cell_pay[i];
      assign next_pri = cell_pri[i];
    end else begin : g_mid
      assign next_pay = cell_pay[i+1];
      assign next_pri = cell_pri[i+1];
    end

    spq_cell #(
      .PAYLOAD_WIDTH (PAYLOAD_WIDTH),
      .PRIORITY_WIDTH(PRIORITY_WIDTH)
    ) u_cell (
      .clk     (clk),
      .ctrl    (ctrl),
      .occupied(CountWidth'(i) < count),
      .new_pay (payload_in),
      .new_pri (priority_in),
      .prev_ge (prev_ge),
      .prev_pay(prev_pay),
      .prev_pri(prev_pri),
      .next_pay(next_pay),
      .next_pri(next_pri),
      .ge      (cell_ge[i]),
      .pay     (cell_pay[i]),
      .pri     (cell_pri[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      count <= count_next;
      done  <= accept;
    end
  end

  always_ff @(posedge clk) begin
    payload_out  <= ctrl.deq ? cell_pay[0] : '0;
    priority_out <= ctrl.deq ? cell_pri[0] : '0;
    status       <= status_next;
    occupancy    <= count_next;
  end

endmodule

// ----- rtl/spq_check.sv -----
// Port-level checks for the stable minimum priority queue, bound to the top level.
module spq_check #(
  parameter int DEPTH          = 16,
  parameter int PAYLOAD_WIDTH  = 32,
  parameter int PRIORITY_WIDTH = 16,
  localparam int CountWidth    = $clog2(DEPTH + 1)
) (
  input logic                             clk,
  input logic                             rst,
  input logic                             start,
  input logic                             busy,
  input logic                             done,
  input logic        [PAYLOAD_WIDTH-1:0]  payload_out,
  input logic signed [PRIORITY_WIDTH-1:0] priority_out,
  input logic        [1:0]                status,
  input logic        [CountWidth-1:0]     occupancy
);

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> done)
    else $error("A transaction produced no result.");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    !(start && !busy) |=> !done)
    else $error("A result appeared without a transaction.");

  a_bounded: assert property (@(posedge clk) disable iff (rst)
    done |-> (occupancy <= CountWidth'(DEPTH)))
    else $error("Occupancy exceeds the depth.");

  a_empty_result: assert property (@(posedge clk) disable iff (rst)
    (done && status == spq_pkg::STATUS_EMPTY) |->
      (payload_out == '0 && priority_out == '0 && occupancy == '0))
    else $error("An empty dequeue returned data or a non-zero occupancy.");

  a_full_result: assert property (@(posedge clk) disable iff (rst)
    (done && status == spq_pkg::STATUS_FULL) |-> (occupancy == CountWidth'(DEPTH)))
    else $error("A rejected enqueue did not report a full queue.");

endmodule

bind stable_min_priority_queue spq_check #(
  .DEPTH         (DEPTH),
  .PAYLOAD_WIDTH (PAYLOAD_WIDTH),
  .PRIORITY_WIDTH(PRIORITY_WIDTH)
) u_spq_check (.*);
